FILE: design/bsp_pkg.sv
// Shared constants, codes and types for the binary search block.
package bsp_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int LEN_W       = IDX_W + 1;
	localparam int DATA_W      = 32;
	localparam int PROBE_W     = 4;
	localparam int MAX_PROBES  = IDX_W + 1;

	localparam logic [PROBE_W-1:0] PROBE_SAT = '1;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} bsp_tbl_req_t;

	typedef struct packed {
		logic               found;
		logic [IDX_W-1:0]   position;
		logic [PROBE_W-1:0] probe_count;
	} bsp_res_t;

endpackage

FILE: design/bsp_table.sv
// Table memory with one write port and one registered read port.
module bsp_table
	import bsp_pkg::*;
(
	input  logic              clk,
	input  bsp_tbl_req_t      req,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [TABLE_DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_data_q <= mem[req.raddr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/bsp_seq.sv
// Search sequencer with the shared compare and midpoint unit.
module bsp_seq
	import bsp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [LEN_W-1:0]  table_length,
	input  logic              start,
	input  logic              func,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [DATA_W-1:0] entry_value,
	input  logic [DATA_W-1:0] search_key,
	input  logic [DATA_W-1:0] rd_data,
	output logic              busy,
	output bsp_tbl_req_t      tbl_req,
	output logic              res_valid,
	output bsp_res_t          res
);

	localparam logic S_IDLE  = 1'b0;
	localparam logic S_PROBE = 1'b1;

	logic               state_q;
	logic [LEN_W-1:0]   lo_q;
	logic [LEN_W-1:0]   hi_q;
	logic [IDX_W-1:0]   mid_q;
	logic [DATA_W-1:0]  key_q;
	logic [PROBE_W-1:0] probes_q;

	logic [LEN_W-1:0]   len;
	logic               lt;
	logic               eq;
	logic [LEN_W-1:0]   lo_n;
	logic [LEN_W-1:0]   hi_n;
	logic [PROBE_W-1:0] probes_n;
	logic [LEN_W:0]     sum;
	logic [IDX_W-1:0]   mid_sel;
	logic               probe_end;
	logic               search_go;

	always_comb begin
		len = (table_length > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : table_length;
		lt = $signed(key_q) < $signed(rd_data);
		eq = (key_q == rd_data);
		hi_n = lt ? {1'b0, mid_q} : hi_q;
		lo_n = lt ? lo_q : ({1'b0, mid_q} + LEN_W'(1));
		probes_n = (probes_q == PROBE_SAT) ? probes_q : (probes_q + PROBE_W'(1));
		if (state_q == S_IDLE) begin
			sum = {1'b0, len} - (LEN_W + 1)'(1);
		end else begin
			sum = {1'b0, lo_n} + {1'b0, hi_n} - (LEN_W + 1)'(1);
		end
		mid_sel = sum[IDX_W:1];
		probe_end = (state_q == S_PROBE) && (eq || (lo_n >= hi_n));
		search_go = start && (func == FUNC_SEARCH);
	end

	assign busy = (state_q == S_PROBE);

	assign tbl_req.we    = start && (func == FUNC_WRITE);
	assign tbl_req.waddr = entry_index;
	assign tbl_req.wdata = entry_value;
	assign tbl_req.raddr = mid_sel;

	always_comb begin
		res_valid = 1'b0;
		res = '0;
		if (state_q == S_PROBE) begin
			res_valid = probe_end;
			res.found = eq;
			res.position = eq ? mid_q : '0;
			res.probe_count = probes_n;
		end else if (search_go && (len == '0)) begin
			res_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (search_go && (len != '0)) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (probe_end) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			lo_q <= '0;
			hi_q <= len;
			mid_q <= mid_sel;
			key_q <= search_key;
			probes_q <= '0;
		end else begin
			lo_q <= lo_n;
			hi_q <= hi_n;
			mid_q <= mid_sel;
			probes_q <= probes_n;
		end
	end

endmodule

FILE: design/binary_search_with_probe_count.sv
// Top level of the binary search block with probe counting.
// A write item is accepted and gives no result.
// A search item makes one table read per probe, up to 11 probes at a length of 1024;
// the result is registered after the last probe.
// An empty table gives its result at the accept edge; new items wait while busy or output is full.
// Reset clears the length register, the sequencer and the output valid; table contents stay undefined.
module binary_search_with_probe_count
	import bsp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic [IDX_W-1:0]    entry_index,
	input  logic [DATA_W-1:0]   entry_value,
	input  logic [DATA_W-1:0]   search_key,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                found,
	output logic [IDX_W-1:0]    position,
	output logic [PROBE_W-1:0]  probe_count,
	input  logic                cfg_we,
	input  logic [LEN_W-1:0]    cfg_wdata
);

	logic [LEN_W-1:0]  table_length_q;
	logic              out_valid_q;
	bsp_res_t          out_res_q;

	logic              busy;
	logic              start;
	bsp_tbl_req_t      tbl_req;
	logic [DATA_W-1:0] rd_data;
	logic              res_valid;
	bsp_res_t          res;

	assign in_ready = !busy && (!out_valid_q || out_ready);
	assign start = in_valid && in_ready;

	bsp_table u_table (
		.clk     (clk),
		.req     (tbl_req),
		.rd_data (rd_data)
	);

	bsp_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.table_length (table_length_q),
		.start        (start),
		.func         (func),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.search_key   (search_key),
		.rd_data      (rd_data),
		.busy         (busy),
		.tbl_req      (tbl_req),
		.res_valid    (res_valid),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				table_length_q <= cfg_wdata;
			end
			if (res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = out_res_q.found;
	assign position    = out_res_q.position;
	assign probe_count = out_res_q.probe_count;

	// A new result must never overwrite one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!out_valid_q || out_ready))
		else $error("result produced while output slot is occupied");

	// A miss always reports position zero.
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.found) |-> (res.position == '0))
		else $error("missed search reports a nonzero position");

	// A hit needs at least one probe and never more than the table depth allows.
	a_hit_probes: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.found) |->
			((res.probe_count != '0) && (res.probe_count <= PROBE_W'(MAX_PROBES))))
		else $error("hit with an impossible probe count");

	// No item is taken while a search is running.
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !start)
		else $error("item accepted during a search");

endmodule
